// File: hw/rtl/rotated_scanout_mapper_core_assert.svh
// Assertion macros for the scan-out mapper.
`ifndef ROTATED_SCANOUT_MAPPER_CORE_ASSERT_SVH
`define ROTATED_SCANOUT_MAPPER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSM_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("rsm assertion failed");
`define RSM_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("rsm assertion failed");
`else
`define RSM_ASSERT(lbl, clk_s, rst_s, prop)
`define RSM_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// File: hw/rtl/rsm_pkg.sv
package rsm_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CW_BITS        = 11;
    localparam int SW_BITS        = 13;
    localparam int IDX_BITS       = 21;
    localparam int PIX_BITS       = 32;
    localparam int LAYOUT_BITS    = 40;
    localparam int NCHAN          = 4;

    // stage map
    localparam int RSM_DEPTH  = 14;
    localparam int DIV_FIRST  = 1;
    localparam int DIV_LAST   = 11;
    localparam int PACK_MUL   = 1;
    localparam int PACK_FIX   = 2;
    localparam int FLIP_STAGE = 12;
    localparam int IDX_STAGE  = 13;

    localparam logic [15:0] RECIP_255 = 16'd32897;  // ceil(2^23 / 255)
    localparam int RECIP_SHIFT = 23;

    localparam logic [CW_BITS-1:0]     CANVAS_W_RST = 11'd640;
    localparam logic [CW_BITS-1:0]     CANVAS_H_RST = 11'd480;
    localparam logic [SW_BITS-1:0]     SCREEN_W_RST = 13'd640;
    localparam logic [SW_BITS-1:0]     SCREEN_H_RST = 13'd480;
    localparam logic [LAYOUT_BITS-1:0] LAYOUT_RST   = 40'd300916416784;

    typedef enum logic [2:0] {
        REG_CANVAS_WIDTH  = 3'd0,
        REG_CANVAS_HEIGHT = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_TURN          = 3'd4,
        REG_NARROW_PIXEL  = 3'd5,
        REG_CHANNEL_LAYOUT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [CW_BITS-1:0]     canvas_width;
        logic [CW_BITS-1:0]     canvas_height;
        logic [SW_BITS-1:0]     screen_width;
        logic [SW_BITS-1:0]     screen_height;
        logic [1:0]             turn;
        logic                   narrow_pixel;
        logic [LAYOUT_BITS-1:0] channel_layout;
    } cfg_t;

    typedef struct packed {
        logic                          mode;
        logic                          oor;
        logic                          zero;
        logic                          flip_x;
        logic                          flip_y;
        logic [SW_BITS-1:0]            dx;
        logic [SW_BITS-1:0]            dy;
        logic [SW_BITS-1:0]            rx;
        logic [SW_BITS-1:0]            ry;
        logic [CW_BITS-1:0]            nx;
        logic [CW_BITS-1:0]            ny;
        logic [CW_BITS-1:0]            qx;
        logic [CW_BITS-1:0]            qy;
        logic [NCHAN-1:0][23:0]        pk_x;
        logic [NCHAN-1:0][16:0]        pk_q;
        logic [PIX_BITS-1:0]           packed_pixel;
        logic [IDX_BITS-1:0]           canvas_index;
    } stage_t;

endpackage

// File: hw/rtl/rsm_datapath.sv
module rsm_datapath #(
    parameter int COORD_BITS = rsm_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  rsm_pkg::cfg_t                 cfg,
    input  logic [rsm_pkg::RSM_DEPTH-1:0] en,
    input  logic                          mode,
    input  logic [COORD_BITS-1:0]         screen_x,
    input  logic [COORD_BITS-1:0]         screen_y,
    input  logic [31:0]                   argb_color,
    output logic [rsm_pkg::IDX_BITS-1:0]  canvas_index,
    output logic [rsm_pkg::PIX_BITS-1:0]  packed_pixel,
    output logic                          out_of_range
);
    import rsm_pkg::*;

    localparam int NUM_BITS = COORD_BITS + CW_BITS;

    stage_t pipe_reg  [RSM_DEPTH];
    stage_t pipe_next [RSM_DEPTH];

    // setup: range check, operand select, numerators, channel products
    always_comb
    begin
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [NUM_BITS-1:0]   num_x;
        logic [NUM_BITS-1:0]   num_y;
        logic [7:0]            chan [NCHAN];
        logic [9:0]            desc;
        logic [4:0]            len;
        logic [15:0]           top;
        stage_t                st;
        st = '0;
        chan[0] = argb_color[23:16];
        chan[1] = argb_color[15:8];
        chan[2] = argb_color[7:0];
        chan[3] = argb_color[31:24];
        ax = cfg.turn[0] ? screen_y : screen_x;
        ay = cfg.turn[0] ? screen_x : screen_y;
        num_x = NUM_BITS'(ax) * NUM_BITS'(cfg.canvas_width);
        num_y = NUM_BITS'(ay) * NUM_BITS'(cfg.canvas_height);
        st.mode   = mode;
        st.oor    = (SW_BITS'(screen_x) >= cfg.screen_width)
                 || (SW_BITS'(screen_y) >= cfg.screen_height);
        st.zero   = (cfg.canvas_width == '0) || (cfg.canvas_height == '0);
        st.flip_x = cfg.turn[1];
        st.flip_y = cfg.turn[1] ^ cfg.turn[0];
        st.dx     = cfg.turn[0] ? cfg.screen_height : cfg.screen_width;
        st.dy     = cfg.turn[0] ? cfg.screen_width : cfg.screen_height;
        st.rx     = SW_BITS'(num_x >> CW_BITS);
        st.ry     = SW_BITS'(num_y >> CW_BITS);
        st.nx     = num_x[CW_BITS-1:0];
        st.ny     = num_y[CW_BITS-1:0];
        for (int c = 0; c < NCHAN; c++)
        begin
            desc = cfg.channel_layout[10*c +: 10];
            len  = (desc[9:5] > 5'd16) ? 5'd16 : desc[9:5];
            top  = 16'((17'd1 << len) - 17'd1);
            st.pk_x[c] = 24'(24'(chan[c]) * 24'(top)) + 24'd127;
        end
        pipe_next[0] = st;
    end

    always_comb
    begin
        stage_t                st;
        logic [SW_BITS:0]      t;
        logic                  ge;
        logic [39:0]           prod;
        logic [24:0]           chk;
        logic [16:0]           q;
        logic [47:0]           shv;
        logic [PIX_BITS-1:0]   pix;
        logic [CW_BITS-1:0]    lx;
        logic [CW_BITS-1:0]    ly;
        logic [2*CW_BITS-1:0]  row;
        st   = '0;
        t    = '0;
        ge   = 1'b0;
        prod = '0;
        chk  = '0;
        q    = '0;
        shv  = '0;
        pix  = '0;
        lx   = '0;
        ly   = '0;
        row  = '0;
        for (int i = 1; i < RSM_DEPTH; i++)
        begin
            st = pipe_reg[i-1];
            if (i >= DIV_FIRST && i <= DIV_LAST)
            begin
                t  = {st.rx, st.nx[CW_BITS-1]};
                ge = t >= {1'b0, st.dx};
                st.rx = ge ? SW_BITS'(t - {1'b0, st.dx}) : t[SW_BITS-1:0];
                st.nx = st.nx << 1;
                st.qx = {st.qx[CW_BITS-2:0], ge};
                t  = {st.ry, st.ny[CW_BITS-1]};
                ge = t >= {1'b0, st.dy};
                st.ry = ge ? SW_BITS'(t - {1'b0, st.dy}) : t[SW_BITS-1:0];
                st.ny = st.ny << 1;
                st.qy = {st.qy[CW_BITS-2:0], ge};
            end
            if (i == PACK_MUL)
            begin
                for (int c = 0; c < NCHAN; c++)
                begin
                    prod = 40'(st.pk_x[c]) * 40'(RECIP_255);
                    st.pk_q[c] = 17'(prod >> RECIP_SHIFT);
                end
            end
            if (i == PACK_FIX)
            begin
                pix = '0;
                for (int c = 0; c < NCHAN; c++)
                begin
                    chk = 25'({st.pk_q[c], 8'b0}) - 25'(st.pk_q[c]);
                    q   = (chk > 25'(st.pk_x[c])) ? 17'(st.pk_q[c] - 17'd1) : st.pk_q[c];
                    shv = 48'(q) << cfg.channel_layout[10*c +: 5];
                    pix = pix | shv[PIX_BITS-1:0];
                end
                if (cfg.narrow_pixel)
                    pix[31:16] = '0;
                st.packed_pixel = st.mode ? pix : '0;
            end
            if (i == FLIP_STAGE)
            begin
                st.qx = st.flip_x ? CW_BITS'(cfg.canvas_width - 11'd1 - st.qx) : st.qx;
                st.qy = st.flip_y ? CW_BITS'(cfg.canvas_height - 11'd1 - st.qy) : st.qy;
            end
            if (i == IDX_STAGE)
            begin
                lx  = st.qx;
                ly  = st.qy;
                row = (2*CW_BITS)'(ly) * (2*CW_BITS)'(cfg.canvas_width);
                st.canvas_index = (st.mode || st.oor || st.zero) ? '0
                                : IDX_BITS'(row + (2*CW_BITS)'(lx));
                st.oor = st.oor && !st.mode;
            end
            pipe_next[i] = st;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RSM_DEPTH; i++)
        begin
            if (en[i])
                pipe_reg[i] <= pipe_next[i];
        end
    end

    assign canvas_index = pipe_reg[RSM_DEPTH-1].canvas_index;
    assign packed_pixel = pipe_reg[RSM_DEPTH-1].packed_pixel;
    assign out_of_range = pipe_reg[RSM_DEPTH-1].oor;

endmodule

// File: hw/rtl/rotated_scanout_mapper_core.sv
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   tuser mode; tdata x, y, argb_color
// m_*      out  m_tvalid/m_tready   tdata canvas_index, packed_pixel, out_of_range
// cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// One transfer per cycle in and out unless m_tready stalls the output; 11 of the
// pipeline stages are the bit-per-stage restoring dividers for the scale terms.
// rst_n clears valid bits and loads register defaults; cfg_ready is always high.
// Each stage holds only while full and the next one holds, so bubbles are squeezed out.
`include "rotated_scanout_mapper_core_assert.svh"

module rotated_scanout_mapper_core #(
    parameter int COORD_BITS = rsm_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,   // mode
    // screen_x, screen_y, argb_color, zero pad
    input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // canvas_index[20:0], packed_pixel[52:21], out_of_range[53], zero pad
    output logic [55:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [rsm_pkg::LAYOUT_BITS-1:0]   cfg_data
);
    import rsm_pkg::*;

    cfg_t                 cfg_reg;
    logic [RSM_DEPTH-1:0] vld_reg;
    logic [RSM_DEPTH-1:0] en;
    logic [IDX_BITS-1:0]  canvas_index;
    logic [PIX_BITS-1:0]  packed_pixel;
    logic                 out_of_range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width   <= CANVAS_W_RST;
            cfg_reg.canvas_height  <= CANVAS_H_RST;
            cfg_reg.screen_width   <= SCREEN_W_RST;
            cfg_reg.screen_height  <= SCREEN_H_RST;
            cfg_reg.turn           <= 2'd0;
            cfg_reg.narrow_pixel   <= 1'b0;
            cfg_reg.channel_layout <= LAYOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CANVAS_WIDTH:   cfg_reg.canvas_width   <= cfg_data[CW_BITS-1:0];
                REG_CANVAS_HEIGHT:  cfg_reg.canvas_height  <= cfg_data[CW_BITS-1:0];
                REG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_data[SW_BITS-1:0];
                REG_SCREEN_HEIGHT:  cfg_reg.screen_height  <= cfg_data[SW_BITS-1:0];
                REG_TURN:           cfg_reg.turn           <= cfg_data[1:0];
                REG_NARROW_PIXEL:   cfg_reg.narrow_pixel   <= cfg_data[0];
                REG_CHANNEL_LAYOUT: cfg_reg.channel_layout <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        en[RSM_DEPTH-1] = !vld_reg[RSM_DEPTH-1] || m_tready;
        for (int i = RSM_DEPTH-2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= s_tvalid;
            for (int i = 1; i < RSM_DEPTH; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[RSM_DEPTH-1];

    rsm_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .cfg         (cfg_reg),
        .en          (en),
        .mode        (s_tuser),
        .screen_x    (s_tdata[COORD_BITS-1:0]),
        .screen_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .argb_color  (s_tdata[2*COORD_BITS+31:2*COORD_BITS]),
        .canvas_index(canvas_index),
        .packed_pixel(packed_pixel),
        .out_of_range(out_of_range)
    );

    assign m_tdata = {2'b00, out_of_range, packed_pixel, canvas_index};

    `RSM_ASSERT(a_oor_index_zero, clk, rst_n, m_tvalid && out_of_range |-> canvas_index == '0)
    `RSM_ASSERT(a_ready_when_drained, clk, rst_n, !vld_reg[RSM_DEPTH-1] |-> s_tready)
    `RSM_ASSERT(a_narrow_upper_zero, clk, rst_n, m_tvalid && cfg_reg.narrow_pixel |-> packed_pixel[31:16] == '0)
    `RSM_ASSERT_ALWAYS(a_no_valid_in_reset, clk, !rst_n |=> !m_tvalid)

endmodule
